// ===== design/line_centroid_steering_core_macros.svh =====
// Assertion macros shared by the line steering modules.
// Each expects signals named clock and reset in the module that uses it.
`ifndef LINE_CENTROID_STEERING_CORE_MACROS_SVH
`define LINE_CENTROID_STEERING_CORE_MACROS_SVH

// Same-cycle implication.
`define LCS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lcs: check failed");

// Next-cycle implication.
`define LCS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lcs: check failed");

`endif

// ===== design/lcs_pkg.sv =====
package lcs_pkg;

   localparam int FRAME_WIDTH_DEFAULT  = 320;
   localparam int FRAME_HEIGHT_DEFAULT = 240;

   localparam int PIXEL_WIDTH     = 8;
   localparam int ROW_WIDTH       = 8;
   localparam int COLUMN_WIDTH    = 9;
   localparam int DRIVE_WIDTH     = 9;
   localparam int OFFSET_WIDTH    = 9;
   localparam int MODE_WIDTH      = 2;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 9;
   localparam int SUM_WIDTH       = 16;
   localparam int COUNT_WIDTH     = 9;
   localparam int QUEUE_DEPTH     = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_BRIGHT_THRESHOLD = 3'd0,
      CSR_BASE_SPEED       = 3'd1,
      CSR_GAIN_Q8          = 3'd2,
      CSR_TURN_SPEED       = 3'd3,
      CSR_SCAN_ROW         = 3'd4,
      CSR_SIDE_COLUMN      = 3'd5,
      CSR_PROBE_ROW        = 3'd6,
      CSR_PROBE_COLUMN     = 3'd7
   } csr_index_type;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_TRACK        = 2'd0,
      MODE_SEARCH_LEFT  = 2'd1,
      MODE_SEARCH_RIGHT = 2'd2
   } steer_mode_type;

   typedef struct packed {
      logic [7:0] bright_threshold;
      logic [6:0] base_speed;
      logic [7:0] gain_q8;
      logic [6:0] turn_speed;
      logic [7:0] scan_row;
      logic [8:0] side_column;
      logic [7:0] probe_row;
      logic [8:0] probe_column;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      bright_threshold: 8'd100,
      base_speed:       7'd35,
      gain_q8:          8'd77,
      turn_speed:       7'd50,
      scan_row:         8'd130,
      side_column:      9'd300,
      probe_row:        8'd5,
      probe_column:     9'd160
   };

   typedef struct packed {
      logic signed [SUM_WIDTH-1:0] offset_sum;
      logic [COUNT_WIDTH-1:0]      bright_count;
      logic                        side_seen;
      logic                        probe_bright;
   } frame_summary_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== design/lcs_if.sv =====
interface lcs_req_if;
   import lcs_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [PIXEL_WIDTH-1:0]  brightness;
   logic [ROW_WIDTH-1:0]    pixel_row;
   logic [COLUMN_WIDTH-1:0] pixel_column;
   logic                    frame_end;

   modport source (output valid, brightness, pixel_row, pixel_column, frame_end,
                   input ready);
   modport sink   (input valid, brightness, pixel_row, pixel_column, frame_end,
                   output ready);
endinterface

interface lcs_rsp_if;
   import lcs_pkg::*;

   logic                           valid;
   logic                           ready;
   logic signed [DRIVE_WIDTH-1:0]  left_drive;
   logic signed [DRIVE_WIDTH-1:0]  right_drive;
   logic                           line_found;
   logic signed [OFFSET_WIDTH-1:0] line_offset;
   logic [MODE_WIDTH-1:0]          steer_mode;

   modport source (output valid, left_drive, right_drive, line_found, line_offset,
                   steer_mode, input ready);
   modport sink   (input valid, left_drive, right_drive, line_found, line_offset,
                   steer_mode, output ready);
endinterface

// ===== design/lcs_front.sv =====
module lcs_front #(
   parameter int FRAME_WIDTH  = lcs_pkg::FRAME_WIDTH_DEFAULT,
   parameter int FRAME_HEIGHT = lcs_pkg::FRAME_HEIGHT_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lcs_pkg::cfg_type           cfg,
   lcs_req_if.sink                    req_bus,
   input  lcs_pkg::queue_status_type  queue_status,
   output logic                       push_valid,
   output lcs_pkg::frame_summary_type push_data
);
   import lcs_pkg::*;

   localparam logic [10:0]        FW_LIMIT = 11'(FRAME_WIDTH);
   localparam logic [10:0]        FH_LIMIT = 11'(FRAME_HEIGHT);
   localparam logic signed [11:0] CENTRE   = 12'(FRAME_WIDTH / 2);
   localparam logic signed [16:0] SUM_MAX  = 17'sd32767;
   localparam logic signed [16:0] SUM_MIN  = -17'sd32768;

   logic signed [SUM_WIDTH-1:0] sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0]      count_ff, count_in;
   logic                        side_ff, side_in;
   logic                        probe_ff, probe_in;

   logic                        accept;
   logic                        hit;
   logic signed [11:0]          diff;
   logic signed [16:0]          sum_wide;

   assign req_bus.ready = !queue_status.full;
   assign accept        = req_bus.valid && req_bus.ready;

   assign hit = ({3'b000, req_bus.pixel_row} < FH_LIMIT)
             && ({2'b00, req_bus.pixel_column} < FW_LIMIT)
             && (req_bus.brightness > cfg.bright_threshold);

   assign diff     = $signed({3'b000, req_bus.pixel_column}) - CENTRE;
   assign sum_wide = {sum_ff[SUM_WIDTH-1], sum_ff} + 17'(diff);

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      side_in  = side_ff;
      probe_in = probe_ff;
      if (hit) begin
         if (req_bus.pixel_row == cfg.scan_row && count_ff != '1) begin
            count_in = count_ff + 1'b1;
            // saturate the running offset
            priority if (sum_wide > SUM_MAX) begin
               sum_in = SUM_MAX[SUM_WIDTH-1:0];
            end else if (sum_wide < SUM_MIN) begin
               sum_in = SUM_MIN[SUM_WIDTH-1:0];
            end else begin
               sum_in = sum_wide[SUM_WIDTH-1:0];
            end
         end
         if (req_bus.pixel_column == cfg.side_column) begin
            side_in = 1'b1;
         end
         if (req_bus.pixel_row == cfg.probe_row && req_bus.pixel_column == cfg.probe_column) begin
            probe_in = 1'b1;
         end
      end
   end

   assign push_valid              = accept && req_bus.frame_end;
   assign push_data.offset_sum    = sum_in;
   assign push_data.bright_count  = count_in;
   assign push_data.side_seen     = side_in;
   assign push_data.probe_bright  = probe_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         side_ff  <= 1'b0;
         probe_ff <= 1'b0;
      end else if (accept) begin
         if (req_bus.frame_end) begin
            sum_ff   <= '0;
            count_ff <= '0;
            side_ff  <= 1'b0;
            probe_ff <= 1'b0;
         end else begin
            sum_ff   <= sum_in;
            count_ff <= count_in;
            side_ff  <= side_in;
            probe_ff <= probe_in;
         end
      end
   end

endmodule

// ===== design/lcs_queue.sv =====
`include "line_centroid_steering_core_macros.svh"

module lcs_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  lcs_pkg::frame_summary_type push_data,
   input  logic                       pop,
   output lcs_pkg::frame_summary_type head_data,
   output lcs_pkg::queue_status_type  status
);
   import lcs_pkg::*;

   localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_SLOT = PTR_WIDTH'(QUEUE_DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] FULL_COUNT = CNT_WIDTH'(QUEUE_DEPTH);

   frame_summary_type       slot_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]    count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign status.full  = (count_ff == FULL_COUNT);
   assign status.empty = (count_ff == '0);
   assign head_data    = slot_ff[rd_ptr_ff];

   assign do_push = push_valid && !status.full;
   assign do_pop  = pop && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `LCS_ASSERT_NOW(push_has_room, push_valid, !status.full)
   `LCS_ASSERT_NOW(count_in_range, 1'b1, count_ff <= FULL_COUNT)
   `LCS_ASSERT_NEXT(push_fills, do_push && !do_pop, count_ff != '0)

endmodule

// ===== design/lcs_back.sv =====
`include "line_centroid_steering_core_macros.svh"

module lcs_back (
   input  logic                       clock,
   input  logic                       reset,
   input  lcs_pkg::cfg_type           cfg,
   input  lcs_pkg::frame_summary_type head_data,
   input  lcs_pkg::queue_status_type  queue_status,
   output logic                       pop,
   lcs_rsp_if.source                  rsp_bus
);
   import lcs_pkg::*;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_CLAMP,
      BK_SCALE,
      BK_MIX
   } back_state_type;

   // 205 / 1024 stands in for one fifth over the outer wheel range
   localparam logic [7:0] FIFTH_RECIP = 8'd205;
   localparam logic signed [10:0] DRIVE_MAX = 11'sd255;
   localparam logic signed [10:0] DRIVE_MIN = -11'sd255;

   back_state_type              state_ff, state_in;
   logic [SUM_WIDTH-1:0]        dvd_ff, dvd_in;
   logic [SUM_WIDTH-1:0]        quot_ff, quot_in;
   logic [COUNT_WIDTH:0]        rem_ff, rem_in;
   logic [COUNT_WIDTH-1:0]      count_ff, count_in;
   logic [3:0]                  step_ff, step_in;
   logic                        neg_ff, neg_in;
   logic                        side_ff, side_in;
   logic                        probe_ff, probe_in;
   logic signed [8:0]           mean_ff, mean_in;
   logic signed [17:0]          product_ff, product_in;
   steer_mode_type              mode_ff, mode_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [8:0]           left_ff, left_in;
   logic signed [8:0]           right_ff, right_in;
   logic                        found_ff, found_in;
   logic signed [8:0]           offset_ff, offset_in;
   logic [MODE_WIDTH-1:0]       smode_ff, smode_in;

   logic [COUNT_WIDTH:0]        trial;
   logic                        take;
   logic [16:0]                 magnitude;
   logic [9:0]                  turn_x6;
   logic [17:0]                 outer_wide;
   logic signed [8:0]           outer;
   logic signed [8:0]           turn_s;
   logic signed [17:0]          p_biased;
   logic signed [9:0]           p;
   logic signed [10:0]          base_s;
   logic signed [10:0]          sum_left;
   logic signed [10:0]          sum_right;
   logic                        load;

   assign trial     = {rem_ff[COUNT_WIDTH-1:0], dvd_ff[SUM_WIDTH-1]};
   assign take      = trial >= {1'b0, count_ff};
   assign magnitude = 17'd0 - {head_data.offset_sum[SUM_WIDTH-1], head_data.offset_sum};

   assign turn_x6    = {3'b000, cfg.turn_speed} * 10'd6;
   assign outer_wide = 18'(turn_x6) * 18'(FIFTH_RECIP);
   assign outer      = $signed({1'b0, outer_wide[17:10]});
   assign turn_s     = $signed({2'b00, cfg.turn_speed});

   // truncate the Q8 product toward zero
   assign p_biased  = product_ff + (product_ff[17] ? 18'sd255 : 18'sd0);
   assign p         = p_biased[17:8];
   assign base_s    = $signed({4'b0000, cfg.base_speed});
   assign sum_left  = base_s + 11'(p);
   assign sum_right = base_s - 11'(p);

   assign load = (state_ff == BK_MIX) && (!rsp_valid_ff || rsp_bus.ready);
   assign pop  = (state_ff == BK_IDLE) && !queue_status.empty;

   always_comb begin
      state_in     = state_ff;
      dvd_in       = dvd_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      neg_in       = neg_ff;
      side_in      = side_ff;
      probe_in     = probe_ff;
      mean_in      = mean_ff;
      product_in   = product_ff;
      mode_in      = mode_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      found_in     = found_ff;
      offset_in    = offset_ff;
      smode_in     = smode_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      unique case (state_ff)
         BK_IDLE: begin
            if (pop) begin
               neg_in   = head_data.offset_sum[SUM_WIDTH-1];
               dvd_in   = head_data.offset_sum[SUM_WIDTH-1] ? magnitude[SUM_WIDTH-1:0]
                                                            : head_data.offset_sum;
               count_in = head_data.bright_count;
               side_in  = head_data.side_seen;
               probe_in = head_data.probe_bright;
               quot_in  = '0;
               rem_in   = '0;
               step_in  = '0;
               state_in = (head_data.bright_count != '0) ? BK_DIVIDE : BK_CLAMP;
            end
         end
         BK_DIVIDE: begin
            rem_in  = take ? trial - {1'b0, count_ff} : trial;
            quot_in = {quot_ff[SUM_WIDTH-2:0], take};
            dvd_in  = {dvd_ff[SUM_WIDTH-2:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == '1) begin
               state_in = BK_CLAMP;
            end
         end
         BK_CLAMP: begin
            // clamp the mean to -256..255
            if (neg_ff) begin
               mean_in = (quot_ff > 16'd256) ? 9'sh100 : 9'(16'd0 - quot_ff);
            end else begin
               mean_in = (quot_ff > 16'd255) ? 9'sd255 : $signed(quot_ff[8:0]);
            end
            state_in = BK_SCALE;
         end
         BK_SCALE: begin
            product_in = 18'(mean_ff) * 18'($signed({1'b0, cfg.gain_q8}));
            state_in   = BK_MIX;
         end
         BK_MIX: begin
            if (load) begin
               found_in  = (count_ff != '0);
               offset_in = mean_ff;
               unique case (mode_ff)
                  MODE_SEARCH_LEFT: begin
                     left_in  = outer;
                     right_in = -turn_s;
                     mode_in  = probe_ff ? MODE_TRACK : MODE_SEARCH_LEFT;
                  end
                  MODE_SEARCH_RIGHT: begin
                     left_in  = -outer;
                     right_in = turn_s;
                     mode_in  = probe_ff ? MODE_TRACK : MODE_SEARCH_RIGHT;
                  end
                  default: begin
                     if (count_ff != '0) begin
                        priority if (sum_left > DRIVE_MAX) left_in = 9'sd255;
                        else if (sum_left < DRIVE_MIN)     left_in = -9'sd255;
                        else                               left_in = sum_left[8:0];
                        priority if (sum_right > DRIVE_MAX) right_in = 9'sd255;
                        else if (sum_right < DRIVE_MIN)     right_in = -9'sd255;
                        else                                right_in = sum_right[8:0];
                        mode_in = MODE_TRACK;
                     end else begin
                        left_in  = base_s[8:0];
                        right_in = base_s[8:0];
                        mode_in  = side_ff ? MODE_SEARCH_LEFT : MODE_SEARCH_RIGHT;
                     end
                  end
               endcase
               smode_in     = mode_in;
               rsp_valid_in = 1'b1;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         mode_ff      <= MODE_TRACK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dvd_ff     <= dvd_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      count_ff   <= count_in;
      step_ff    <= step_in;
      neg_ff     <= neg_in;
      side_ff    <= side_in;
      probe_ff   <= probe_in;
      mean_ff    <= mean_in;
      product_ff <= product_in;
      left_ff    <= left_in;
      right_ff   <= right_in;
      found_ff   <= found_in;
      offset_ff  <= offset_in;
      smode_ff   <= smode_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.left_drive  = left_ff;
   assign rsp_bus.right_drive = right_ff;
   assign rsp_bus.line_found  = found_ff;
   assign rsp_bus.line_offset = offset_ff;
   assign rsp_bus.steer_mode  = smode_ff;

   `LCS_ASSERT_NOW(divisor_nonzero, state_ff == BK_DIVIDE, count_ff != '0)
   `LCS_ASSERT_NOW(result_from_mix, $rose(rsp_valid_ff), $past(state_ff) == BK_MIX)
   `LCS_ASSERT_NEXT(pop_starts_work, pop, state_ff == BK_DIVIDE || state_ff == BK_CLAMP)

endmodule

// ===== design/line_centroid_steering_core.sv =====
// Line-following steering from a raster pixel stream. One pixel transfer is taken
// every clock; the pixel stream only stalls when two finished frames are still
// queued for the steering stage. On the pixel marked frame_end the frame's scan-row
// sum, bright count, side and probe flags go into a two-entry queue, and one result
// follows when the result port is free: the summary is loaded, the bit-serial divider
// forms the mean offset, then come clamp, gain multiply and drive mix. A frame with
// no bright scan-row pixel skips the divider. Configuration writes take effect on
// the next clock and are meant to be made while no frame is in flight. Pixels
// outside the frame size still act on their frame_end mark.
module line_centroid_steering_core #(
   parameter int FRAME_WIDTH  = lcs_pkg::FRAME_WIDTH_DEFAULT,
   parameter int FRAME_HEIGHT = lcs_pkg::FRAME_HEIGHT_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   lcs_req_if.sink                              req_bus,
   lcs_rsp_if.source                            rsp_bus,
   input  logic                                 csr_write_enable,
   input  logic [lcs_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [lcs_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data
);
   import lcs_pkg::*;

   cfg_type           cfg_ff, cfg_in;
   logic              push_valid;
   frame_summary_type push_data;
   frame_summary_type head_data;
   queue_status_type  queue_status;
   logic              pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_BRIGHT_THRESHOLD: cfg_in.bright_threshold = csr_write_data[7:0];
            CSR_BASE_SPEED:       cfg_in.base_speed       = csr_write_data[6:0];
            CSR_GAIN_Q8:          cfg_in.gain_q8          = csr_write_data[7:0];
            CSR_TURN_SPEED:       cfg_in.turn_speed       = csr_write_data[6:0];
            CSR_SCAN_ROW:         cfg_in.scan_row         = csr_write_data[7:0];
            CSR_SIDE_COLUMN:      cfg_in.side_column      = csr_write_data[8:0];
            CSR_PROBE_ROW:        cfg_in.probe_row        = csr_write_data[7:0];
            CSR_PROBE_COLUMN:     cfg_in.probe_column     = csr_write_data[8:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lcs_front #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_bus      (req_bus),
      .queue_status (queue_status),
      .push_valid   (push_valid),
      .push_data    (push_data)
   );

   lcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .head_data  (head_data),
      .status     (queue_status)
   );

   lcs_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .head_data    (head_data),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_bus      (rsp_bus)
   );

endmodule

// ===== test/line_centroid_steering_core_tb.sv =====
`timescale 1ns / 1ps

module line_centroid_steering_core_tb;
   import lcs_pkg::*;

   localparam int RANDOM_ITEMS  = 750;
   localparam int DRAIN_CYCLES  = 40;
   localparam int LONG_HOLD     = 400;
   localparam int STALL_LIMIT   = 4000;
   localparam int REG_TOP [8]   = '{255, 100, 255, 100, 239, 319, 239, 319};

   typedef struct packed {
      logic [7:0] brightness;
      logic [7:0] row;
      logic [8:0] column;
      logic       frame_end;
   } pixel_type;

   typedef struct packed {
      logic signed [8:0] left_drive;
      logic signed [8:0] right_drive;
      logic              line_found;
      logic signed [8:0] line_offset;
      steer_mode_type    steer_mode;
   } steer_cmd_type;

   typedef struct packed {
      pixel_type     px;
      logic          typed;
      steer_cmd_type cmd;
   } directed_row_type;

   logic          clock;
   logic          reset;
   logic          csr_write_enable;
   csr_index_type csr_index;
   logic [8:0]    csr_write_data;

   lcs_req_if pixel_bus ();
   lcs_rsp_if steer_bus ();

   line_centroid_steering_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (pixel_bus),
      .rsp_bus          (steer_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Frame state and settings as the block should hold them
   cfg_type        cfg = CFG_RESET;
   int             offset_total = 0;
   int             bright_total = 0;
   bit             side_hit = 0;
   bit             probe_hit = 0;
   steer_mode_type track_mode = MODE_TRACK;

   steer_cmd_type     expected_steering [$];
   directed_row_type  table_notes [$];
   int                fault_count = 0;
   int                quiet_cycles = 0;
   int                hold_asks = 0;
   int                holds_served = 0;
   int                burst_left = 0;
   int                random_sent = 0;

   directed_row_type stim_table [19] = '{
      '{'{8'd0,   8'd130, 9'd0,   1'b1}, 1'b1,
        '{9'sd35, 9'sd35, 1'b0, 9'sd0, MODE_SEARCH_RIGHT}},
      '{'{8'd255, 8'd5,   9'd160, 1'b1}, 1'b1,
        '{-9'sd60, 9'sd50, 1'b0, 9'sd0, MODE_TRACK}},
      '{'{8'd255, 8'd130, 9'd319, 1'b0}, 1'b0, '0},
      '{'{8'd255, 8'd130, 9'd319, 1'b1}, 1'b0, '0},
      '{'{8'd255, 8'd130, 9'd0,   1'b1}, 1'b0, '0},
      '{'{8'd255, 8'd130, 9'd160, 1'b1}, 1'b1,
        '{9'sd35, 9'sd35, 1'b1, 9'sd0, MODE_TRACK}},
      '{'{8'd255, 8'd240, 9'd0,   1'b0}, 1'b0, '0},
      '{'{8'd255, 8'd130, 9'd320, 1'b0}, 1'b0, '0},
      '{'{8'd255, 8'd255, 9'd511, 1'b1}, 1'b1,
        '{9'sd35, 9'sd35, 1'b0, 9'sd0, MODE_SEARCH_RIGHT}},
      '{'{8'd100, 8'd5,   9'd160, 1'b1}, 1'b1,
        '{-9'sd60, 9'sd50, 1'b0, 9'sd0, MODE_SEARCH_RIGHT}},
      '{'{8'd101, 8'd5,   9'd160, 1'b1}, 1'b1,
        '{-9'sd60, 9'sd50, 1'b0, 9'sd0, MODE_TRACK}},
      '{'{8'd200, 8'd0,   9'd300, 1'b0}, 1'b0, '0},
      '{'{8'd0,   8'd130, 9'd5,   1'b1}, 1'b1,
        '{9'sd35, 9'sd35, 1'b0, 9'sd0, MODE_SEARCH_LEFT}},
      '{'{8'd255, 8'd130, 9'd200, 1'b1}, 1'b0, '0},
      '{'{8'd255, 8'd5,   9'd160, 1'b1}, 1'b1,
        '{9'sd60, -9'sd50, 1'b0, 9'sd0, MODE_TRACK}},
      '{'{8'd255, 8'd130, 9'd100, 1'b0}, 1'b0, '0},
      '{'{8'd255, 8'd130, 9'd101, 1'b0}, 1'b0, '0},
      '{'{8'd0,   8'd130, 9'd300, 1'b1}, 1'b0, '0},
      '{'{8'd255, 8'd130, 9'd300, 1'b1}, 1'b0, '0}
   };

   function automatic int clamp(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Accumulate one pixel; on frame_end work out the steering command.
   function automatic bit absorb_pixel(input pixel_type px, output steer_cmd_type cmd);
      int  mean;
      int  outer;
      int  left;
      int  right;
      int  lift;
      bit  found;
      mean = 0;
      cmd = '0;
      if (px.row < FRAME_HEIGHT_DEFAULT && px.column < FRAME_WIDTH_DEFAULT &&
          px.brightness > cfg.bright_threshold) begin
         if (px.row == cfg.scan_row && bright_total < 511) begin
            bright_total++;
            offset_total = clamp(offset_total + int'(px.column) - FRAME_WIDTH_DEFAULT / 2,
                                 -32768, 32767);
         end
         if (px.column == cfg.side_column) side_hit = 1;
         if (px.row == cfg.probe_row && px.column == cfg.probe_column) probe_hit = 1;
      end
      if (!px.frame_end) return 0;

      found = bright_total != 0;
      if (found) mean = clamp(offset_total / bright_total, -256, 255);
      outer = int'(cfg.turn_speed) * 6 / 5;
      if (track_mode == MODE_SEARCH_LEFT || track_mode == MODE_SEARCH_RIGHT) begin
         if (track_mode == MODE_SEARCH_LEFT) begin
            right = -int'(cfg.turn_speed);
            left = outer;
         end else begin
            right = int'(cfg.turn_speed);
            left = -outer;
         end
         if (probe_hit) track_mode = MODE_TRACK;
      end else if (found) begin
         lift = (mean * int'(cfg.gain_q8)) / 256;
         left = clamp(int'(cfg.base_speed) + lift, -255, 255);
         right = clamp(int'(cfg.base_speed) - lift, -255, 255);
         track_mode = MODE_TRACK;
      end else begin
         left = int'(cfg.base_speed);
         right = int'(cfg.base_speed);
         track_mode = side_hit ? MODE_SEARCH_LEFT : MODE_SEARCH_RIGHT;
      end

      cmd.left_drive = left[8:0];
      cmd.right_drive = right[8:0];
      cmd.line_found = found;
      cmd.line_offset = mean[8:0];
      cmd.steer_mode = track_mode;
      offset_total = 0;
      bright_total = 0;
      side_hit = 0;
      probe_hit = 0;
      return 1;
   endfunction

   function automatic void check_field(string label, logic [8:0] want, logic [8:0] got);
      if (got !== want) begin
         fault_count++;
         $display("%0t %s expected %0d got %0d", $time, label, $signed(want), $signed(got));
      end
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      int        kind;
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 4))
         0: px.brightness = cfg.bright_threshold;
         1: px.brightness = cfg.bright_threshold + 8'd1;
         2: px.brightness = 8'd255;
         default: px.brightness = 8'($urandom_range(0, 255));
      endcase
      if (kind < 50) begin
         px.row = cfg.scan_row;
         if ($urandom_range(0, 2) == 0) px.column = $urandom_range(0, 1) ? 9'd319 : 9'd0;
         else px.column = 9'($urandom_range(0, 319));
      end else if (kind < 62) begin
         px.row = 8'($urandom_range(0, 239));
         px.column = cfg.side_column;
      end else if (kind < 72) begin
         px.row = cfg.probe_row;
         px.column = cfg.probe_column;
      end else if (kind < 90) begin
         px.row = 8'($urandom_range(0, 239));
         px.column = 9'($urandom_range(0, 319));
      end else begin
         px.row = 8'($urandom_range(0, 255));
         px.column = 9'($urandom_range(0, 511));
      end
      px.frame_end = 1'b0;
      return px;
   endfunction

   // Offer one pixel, idling between bursts, and hold until the transfer.
   task automatic send_pixel(input pixel_type px);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                                  : $urandom_range(1, 30);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            pixel_bus.valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      pixel_bus.valid = 1'b1;
      pixel_bus.brightness = px.brightness;
      pixel_bus.pixel_row = px.row;
      pixel_bus.pixel_column = px.column;
      pixel_bus.frame_end = px.frame_end;
      do @(posedge clock); while (!pixel_bus.ready);
      burst_left--;
   endtask

   // Drop valid, wait for every command to come back, then let the block go quiet.
   task automatic settle();
      @(negedge clock);
      pixel_bus.valid = 1'b0;
      while (expected_steering.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [8:0] value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = value;
      case (idx)
         CSR_BRIGHT_THRESHOLD: cfg.bright_threshold = value[7:0];
         CSR_BASE_SPEED:       cfg.base_speed = value[6:0];
         CSR_GAIN_Q8:          cfg.gain_q8 = value[7:0];
         CSR_TURN_SPEED:       cfg.turn_speed = value[6:0];
         CSR_SCAN_ROW:         cfg.scan_row = value[7:0];
         CSR_SIDE_COLUMN:      cfg.side_column = value;
         CSR_PROBE_ROW:        cfg.probe_row = value[7:0];
         CSR_PROBE_COLUMN:     cfg.probe_column = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      steer_cmd_type    cmd;
      steer_cmd_type    want;
      directed_row_type note;
      bit               fired;
      if (!reset) begin
         if (steer_bus.valid && steer_bus.ready) begin
            if (expected_steering.size() == 0) begin
               fault_count++;
               $display("%0t unexpected steering transfer: expected none got %0d %0d",
                        $time, steer_bus.left_drive, steer_bus.right_drive);
            end else begin
               want = expected_steering.pop_front();
               check_field("left_drive", want.left_drive, steer_bus.left_drive);
               check_field("right_drive", want.right_drive, steer_bus.right_drive);
               check_field("line_found", want.line_found, steer_bus.line_found);
               check_field("line_offset", want.line_offset, steer_bus.line_offset);
               check_field("steer_mode", want.steer_mode, steer_bus.steer_mode);
            end
         end
         if (pixel_bus.valid && pixel_bus.ready) begin
            fired = absorb_pixel({pixel_bus.brightness, pixel_bus.pixel_row,
                                  pixel_bus.pixel_column, pixel_bus.frame_end}, cmd);
            if (table_notes.size() != 0) begin
               note = table_notes.pop_front();
               if (note.typed) cmd = note.cmd;
            end
            if (fired) expected_steering.push_back(cmd);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (pixel_bus.valid && pixel_bus.ready) ||
          (steer_bus.valid && steer_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: alternate runs of ready and stall, with the odd long hold-off.
   initial begin
      int run;
      bit granting;
      run = 0;
      granting = 0;
      steer_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asks != holds_served) begin
            holds_served++;
            steer_bus.ready = 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            run = 0;
            granting = 0;
            continue;
         end
         if (run == 0) begin
            granting = !granting;
            if (granting) run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                            : $urandom_range(1, 20);
            else run = $urandom_range(1, 10);
         end
         steer_bus.ready = granting;
         run--;
      end
   end

   initial begin
      pixel_type     px;
      csr_index_type idx;
      logic [8:0]    value;
      int            phase;
      int            phase_pixels;
      int            frame_len;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_BRIGHT_THRESHOLD;
      csr_write_data = '0;
      pixel_bus.valid = 1'b0;
      pixel_bus.brightness = '0;
      pixel_bus.pixel_row = '0;
      pixel_bus.pixel_column = '0;
      pixel_bus.frame_end = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (stim_table[i]) begin
         table_notes.push_back(stim_table[i]);
         send_pixel(stim_table[i].px);
      end
      settle();

      // Overrun the bright count and the sum, high side then low side
      for (int n = 0; n < 520; n++)
         send_pixel('{8'($urandom_range(101, 255)), 8'd130, 9'd319, n == 519});
      for (int n = 0; n < 210; n++)
         send_pixel('{8'($urandom_range(101, 255)), 8'd130, 9'd0, n == 209});
      settle();

      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         idx = idx.first();
         do begin
            case (phase % 4)
               1: value = '0;
               2: value = 9'(REG_TOP[idx]);
               3: value = (idx == CSR_BASE_SPEED || idx == CSR_GAIN_Q8) ?
                          9'(REG_TOP[idx]) : 9'($urandom_range(0, REG_TOP[idx]));
               default:
                  case ($urandom_range(0, 3))
                     0: value = '0;
                     1: value = 9'(REG_TOP[idx]);
                     default: value = 9'($urandom_range(0, REG_TOP[idx]));
                  endcase
            endcase
            write_reg(idx, value);
            idx = idx.next();
         end while (idx != idx.first());
         @(negedge clock);
         csr_write_enable = 1'b0;

         // Stall the receiver while short frames pile up behind it
         if (phase == 2) hold_asks++;
         phase_pixels = 0;
         while (phase_pixels < 100) begin
            if (phase == 2) frame_len = $urandom_range(1, 2);
            else frame_len = $urandom_range(0, 1) ? $urandom_range(1, 4)
                                                  : $urandom_range(5, 40);
            for (int n = 0; n < frame_len; n++) begin
               px = random_pixel();
               px.frame_end = (n == frame_len - 1);
               send_pixel(px);
            end
            phase_pixels += frame_len;
         end
         random_sent += phase_pixels;
         settle();
         phase++;
      end

      if (fault_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/lcs_pkg.sv
design/lcs_if.sv
design/lcs_front.sv
design/lcs_queue.sv
design/lcs_back.sv
design/line_centroid_steering_core.sv
test/line_centroid_steering_core_tb.sv
